[rtl/core/gssa_pkg.sv]
package gssa_pkg;

    // Default geometry of the stack area
    localparam int DEF_MAX_SLOTS   = 256;
    localparam int DEF_SLOT_PAGES  = 8;
    localparam int DEF_GUARD_PAGES = 1;
    localparam int DEF_PAGE_BYTES  = 4096;

    localparam int ADDR_W   = 64;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;
    localparam int SLOTNO_W = 8;
    localparam int BMAP_W   = 64;

    // Request kinds
    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFREE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd2;

    typedef struct packed {
        logic load;
        logic sub;
        logic cmp;
        logic div_step;
        logic slot_rd;
        logic slot_upd;
        logic scan_chk;
        logic mul;
        logic add;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic in_area;
        logic div_last;
        logic found;
        logic scan_last;
        logic out_free;
    } t_dp_sts;

endpackage

[rtl/core/gssa_ram.sv]
module gssa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/gssa_datapath.sv]
module gssa_datapath #(
    parameter int MAX_SLOTS   = gssa_pkg::DEF_MAX_SLOTS,
    parameter int SLOT_PAGES  = gssa_pkg::DEF_SLOT_PAGES,
    parameter int GUARD_PAGES = gssa_pkg::DEF_GUARD_PAGES,
    parameter int PAGE_BYTES  = gssa_pkg::DEF_PAGE_BYTES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  gssa_pkg::t_dp_cmd                 i_cmd,
    output gssa_pkg::t_dp_sts                 o_sts,
    input  logic                              i_cfg_we,
    input  logic [gssa_pkg::ADDR_W-1:0]       i_cfg_wdata,
    input  logic [gssa_pkg::REQ_W-1:0]        i_req,
    input  logic [gssa_pkg::ADDR_W-1:0]       i_addr,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [gssa_pkg::STATUS_W-1:0]     o_status,
    output logic [gssa_pkg::ADDR_W-1:0]       o_base,
    output logic [gssa_pkg::SLOTNO_W-1:0]     o_slot,
    output logic                              o_hit
);

    localparam int BW         = gssa_pkg::BMAP_W;
    localparam int WORD_COUNT = (MAX_SLOTS + BW - 1) / BW;
    localparam int WW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int BIT_W      = $clog2(BW);
    localparam int SW         = $clog2(MAX_SLOTS);
    localparam int STEP_W     = 2;
    localparam logic [63:0] SLOT_BYTES  = 64'(SLOT_PAGES) * 64'(PAGE_BYTES);
    localparam logic [63:0] GUARD_BYTES = 64'(GUARD_PAGES) * 64'(PAGE_BYTES);
    localparam logic [63:0] AREA_BYTES  = 64'(MAX_SLOTS) * SLOT_BYTES;
    localparam int AW         = $clog2(AREA_BYTES) + 1;
    // Reciprocal of the slot size scaled by 2^AW
    localparam logic [63:0] RECIP = (64'(1) << AW) / SLOT_BYTES;
    localparam int RW         = $clog2(RECIP + 64'd1);
    localparam int PW         = AW + RW;
    localparam int LAST_BITS  = MAX_SLOTS - (WORD_COUNT - 1) * BW;
    localparam logic [BW-1:0] PAD_MASK =
        (LAST_BITS == BW) ? '0 : ~((BW'(1) << LAST_BITS) - BW'(1));
    localparam logic [WW-1:0] LAST_WORD = WW'(WORD_COUNT - 1);

    logic [gssa_pkg::ADDR_W-1:0]   r_area;
    logic [gssa_pkg::REQ_W-1:0]    r_req;
    logic [gssa_pkg::ADDR_W-1:0]   r_addr;
    logic [gssa_pkg::ADDR_W-1:0]   r_off;
    logic                          r_ge;
    logic [AW-1:0]                 r_rem;
    logic [STEP_W-1:0]             r_step;
    logic [SW-1:0]                 r_idx;
    logic [WW-1:0]                 r_word;
    logic [gssa_pkg::ADDR_W-1:0]   r_prod;
    logic [gssa_pkg::STATUS_W-1:0] r_status;
    logic [gssa_pkg::ADDR_W-1:0]   r_base;
    logic                          r_hit;
    logic [WORD_COUNT-1:0]         r_wvalid;
    logic                          r_rd_vld;
    logic                          r_ovalid;
    logic [gssa_pkg::STATUS_W-1:0] r_ostatus;
    logic [gssa_pkg::ADDR_W-1:0]   r_obase;
    logic [gssa_pkg::SLOTNO_W-1:0] r_oslot;
    logic                          r_ohit;

    logic [gssa_pkg::ADDR_W:0]     w_diff;
    logic                          w_inside;
    logic [PW-1:0]                 w_qprod;
    logic [AW-1:0]                 w_qd;
    logic [BW-1:0]                 w_rd_data;
    logic [BW-1:0]                 w_rd_eff;
    logic [BW-1:0]                 w_srch;
    logic                          w_found;
    logic [BIT_W-1:0]              w_bit;
    logic [BIT_W-1:0]              w_sbit;
    logic [WW-1:0]                 w_sword;
    logic [WW-1:0]                 w_raddr;
    logic                          w_we;
    logic [WW-1:0]                 w_waddr;
    logic [BW-1:0]                 w_wdata;

    assign w_diff   = {1'b0, r_addr} - {1'b0, r_area};
    assign w_inside = r_ge && (r_off < AREA_BYTES);
    assign w_qprod  = PW'(r_rem) * PW'(RECIP);
    assign w_qd     = AW'(r_idx) * AW'(SLOT_BYTES);
    assign w_sbit   = r_idx[BIT_W-1:0];
    assign w_sword  = WW'(r_idx >> BIT_W);
    assign w_raddr  = i_cmd.slot_rd ? w_sword : r_word;
    assign w_rd_eff = r_rd_vld ? w_rd_data : '0;
    // Slots past the end of a partial last word count as taken
    assign w_srch   = w_rd_eff | ((r_word == LAST_WORD) ? PAD_MASK : '0);

    always_comb begin
        w_found = 1'b0;
        w_bit   = '0;
        for (int i = BW - 1; i >= 0; i--) begin
            if (!w_srch[i]) begin
                w_found = 1'b1;
                w_bit   = BIT_W'(i);
            end
        end
    end

    assign w_we    = (i_cmd.scan_chk && w_found) ||
                     (i_cmd.slot_upd && (r_req == gssa_pkg::REQ_FREE));
    assign w_waddr = i_cmd.slot_upd ? w_sword : r_word;
    assign w_wdata = i_cmd.slot_upd ? (w_rd_eff & ~(BW'(1) << w_sbit))
                                    : (w_rd_eff | (BW'(1) << w_bit));

    gssa_ram #(
        .WIDTH(BW),
        .DEPTH(WORD_COUNT)
    ) u_bmap (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area   <= '0;
            r_wvalid <= '0;
            r_rd_vld <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_area <= i_cfg_wdata;
            end
            if (w_we) begin
                r_wvalid[w_waddr] <= 1'b1;
            end
            r_rd_vld <= r_wvalid[w_raddr];
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req    <= i_req;
            r_addr   <= i_addr;
            r_status <= gssa_pkg::ST_OK;
            r_base   <= '0;
            r_idx    <= '0;
            r_hit    <= 1'b0;
            r_word   <= '0;
        end
        if (i_cmd.sub) begin
            r_off <= w_diff[gssa_pkg::ADDR_W-1:0];
            r_ge  <= !w_diff[gssa_pkg::ADDR_W];
        end
        if (i_cmd.cmp) begin
            if (!w_inside) begin
                r_status <= gssa_pkg::ST_OUTSIDE;
            end
            r_rem  <= AW'(r_off);
            r_idx  <= '0;
            r_step <= STEP_W'(2);
        end
        // Slot division by reciprocal multiply: estimate, remainder, then one correction
        if (i_cmd.div_step) begin
            if (r_step == STEP_W'(2)) begin
                r_idx <= w_qprod[AW +: SW];
            end else if (r_step == STEP_W'(1)) begin
                r_rem <= r_rem - w_qd;
            end else if (r_rem >= AW'(SLOT_BYTES)) begin
                // the estimate can fall one short
                r_rem <= r_rem - AW'(SLOT_BYTES);
                r_idx <= r_idx + SW'(1);
            end
            r_step <= r_step - STEP_W'(1);
        end
        if (i_cmd.slot_upd && (r_req == gssa_pkg::REQ_QUERY)) begin
            r_hit <= (r_rem < AW'(GUARD_BYTES)) && w_rd_eff[w_sbit];
        end
        if (i_cmd.scan_chk) begin
            if (w_found) begin
                r_idx <= SW'({r_word, w_bit});
            end else if (r_word == LAST_WORD) begin
                r_status <= gssa_pkg::ST_NOFREE;
            end else begin
                r_word <= r_word + WW'(1);
            end
        end
        if (i_cmd.mul) begin
            r_prod <= 64'(w_qd) + GUARD_BYTES;
        end
        if (i_cmd.add) begin
            r_base <= r_area + r_prod;
        end
        if (i_cmd.out_load) begin
            r_ostatus <= r_status;
            r_obase   <= r_base;
            r_oslot   <= gssa_pkg::SLOTNO_W'(r_idx);
            r_ohit    <= r_hit;
        end
    end

    assign o_sts.in_area   = w_inside;
    assign o_sts.div_last  = (r_step == '0);
    assign o_sts.found     = w_found;
    assign o_sts.scan_last = (r_word == LAST_WORD);
    assign o_sts.out_free  = !r_ovalid || i_out_ready;

    assign o_out_valid = r_ovalid;
    assign o_status    = r_ostatus;
    assign o_base      = r_obase;
    assign o_slot      = r_oslot;
    assign o_hit       = r_ohit;

    a_alloc_marks_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.scan_chk && w_found) |=> r_wvalid[$past(r_word)])
        else $error("allocated bitmap word not marked written");

    a_hit_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ohit) |-> (r_ostatus == gssa_pkg::ST_OK))
        else $error("guard hit reported with error status");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && (r_ostatus != gssa_pkg::ST_OK)) |-> (r_obase == '0 && r_oslot == '0))
        else $error("error result carries a base or slot");

    a_outside_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.cmp && !w_inside) |=> (r_status == gssa_pkg::ST_OUTSIDE))
        else $error("outside address not flagged");

endmodule

[rtl/core/gssa_ctrl.sv]
module gssa_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [gssa_pkg::REQ_W-1:0] i_req,
    input  gssa_pkg::t_dp_sts          i_sts,
    output gssa_pkg::t_dp_cmd          o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SUB  = 4'd1;
    localparam logic [3:0] S_CMP  = 4'd2;
    localparam logic [3:0] S_DIV  = 4'd3;
    localparam logic [3:0] S_SRD  = 4'd4;
    localparam logic [3:0] S_SUPD = 4'd5;
    localparam logic [3:0] S_ARD  = 4'd6;
    localparam logic [3:0] S_ACHK = 4'd7;
    localparam logic [3:0] S_MUL  = 4'd8;
    localparam logic [3:0] S_ADD  = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_req)
                        gssa_pkg::REQ_ALLOC: n_state = S_ARD;
                        gssa_pkg::REQ_FREE,
                        gssa_pkg::REQ_QUERY: n_state = S_SUB;
                        default:             n_state = S_DONE;
                    endcase
                end
            end
            S_SUB: begin
                o_cmd.sub = 1'b1;
                n_state   = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = i_sts.in_area ? S_DIV : S_DONE;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_SRD;
                end
            end
            S_SRD: begin
                o_cmd.slot_rd = 1'b1;
                n_state       = S_SUPD;
            end
            S_SUPD: begin
                o_cmd.slot_upd = 1'b1;
                n_state        = S_DONE;
            end
            S_ARD: begin
                n_state = S_ACHK;
            end
            S_ACHK: begin
                o_cmd.scan_chk = 1'b1;
                if (i_sts.found) begin
                    n_state = S_MUL;
                end else if (i_sts.scan_last) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_ARD;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                // Hold until the output register can take the result
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/core/guarded_stack_slot_allocator_unit.sv]
// Allocate scans the bitmap word by word for a free slot, then forms the slot base; free
//   and guard query divide the area offset by the slot size with a reciprocal multiply
//   (an address outside the area ends early); an unused request type goes straight to the result.
// Throughput: one request in flight; a new request is taken as soon as the result is
//   registered, even while that result still waits on m_axis_tready.
// Reset (synchronous, active low) clears the slot bitmap (per-word valid bits) and area_base.
module guarded_stack_slot_allocator_unit #(
    parameter int MAX_SLOTS   = gssa_pkg::DEF_MAX_SLOTS,
    parameter int SLOT_PAGES  = gssa_pkg::DEF_SLOT_PAGES,
    parameter int GUARD_PAGES = gssa_pkg::DEF_GUARD_PAGES,
    parameter int PAGE_BYTES  = gssa_pkg::DEF_PAGE_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [63:0] i_cfg_wdata,    // area_base
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] address
    input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // [63:0] stack_base, [71:64] slot_number,
                                        // [72] guard_hit, [79:73] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    gssa_pkg::t_dp_cmd w_cmd;
    gssa_pkg::t_dp_sts w_sts;

    logic [gssa_pkg::ADDR_W-1:0]   w_base;
    logic [gssa_pkg::SLOTNO_W-1:0] w_slot;
    logic                          w_hit;

    gssa_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(s_axis_tvalid),
        .o_in_ready(s_axis_tready),
        .i_req     (s_axis_tuser),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    gssa_datapath #(
        .MAX_SLOTS  (MAX_SLOTS),
        .SLOT_PAGES (SLOT_PAGES),
        .GUARD_PAGES(GUARD_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_req      (s_axis_tuser),
        .i_addr     (s_axis_tdata),
        .i_out_ready(m_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .o_status   (m_axis_tuser),
        .o_base     (w_base),
        .o_slot     (w_slot),
        .o_hit      (w_hit)
    );

    assign m_axis_tdata = {7'd0, w_hit, w_slot, w_base};

endmodule
